// ===== rtl/core/omg_pkg.sv =====
package omg_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_LEN    = 24;
  localparam int STEP_W       = 5;

  localparam int XY_W  = 34;
  localparam int Z_W   = 28;
  localparam int OP_W  = 33;
  localparam int PR_W  = 2 * OP_W;
  localparam int FL_W  = PR_W - 28;

  localparam logic signed [16:0]    PI_Q13     = 17'sd25736;
  localparam logic signed [17:0]    TWO_PI_Q13 = 18'sd51472;
  localparam logic signed [Z_W-1:0] HALF_PI_Q24 = 28'sd26353589;
  localparam logic signed [Z_W-1:0] PI_Q24      = 28'sd52707178;
  localparam logic signed [XY_W-1:0] GAIN_Q28   = 34'sd163008218;

  localparam logic [23:0] DIST_THR_RST  = 24'd13107;
  localparam logic [14:0] ANGLE_THR_RST = 15'd1638;

  localparam logic [1:0] REG_DIST  = 2'd0;
  localparam logic [1:0] REG_ANGLE = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_VEC,
    ST_HFIN,
    ST_ROT,
    ST_MUL,
    ST_FL,
    ST_SQ,
    ST_FIN
  } state_e;

  function automatic logic signed [Z_W-1:0] atan_q24(input logic [STEP_W-1:0] idx);
    logic signed [Z_W-1:0] r;
    unique case (idx)
      5'd0:  r = 28'sd13176795;
      5'd1:  r = 28'sd7778716;
      5'd2:  r = 28'sd4110060;
      5'd3:  r = 28'sd2086331;
      5'd4:  r = 28'sd1047214;
      5'd5:  r = 28'sd524117;
      5'd6:  r = 28'sd262123;
      5'd7:  r = 28'sd131069;
      5'd8:  r = 28'sd65536;
      5'd9:  r = 28'sd32768;
      5'd10: r = 28'sd16384;
      5'd11: r = 28'sd8192;
      5'd12: r = 28'sd4096;
      5'd13: r = 28'sd2048;
      5'd14: r = 28'sd1024;
      5'd15: r = 28'sd512;
      5'd16: r = 28'sd256;
      5'd17: r = 28'sd128;
      5'd18: r = 28'sd64;
      5'd19: r = 28'sd32;
      5'd20: r = 28'sd16;
      5'd21: r = 28'sd8;
      5'd22: r = 28'sd4;
      5'd23: r = 28'sd2;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/odometry_motion_gate_unit.sv =====
// Odometry motion gate.
// Input channel: one pose word per item (odom_x_i, odom_y_i, quat_z_i, quat_w_i),
// taken when in_valid_i is high and in_stall_o is low.
// Output channel: one result word per item (moved_o and the three deltas), held
// in an output register; out_valid_o stays up until a cycle with out_stall_i low.
// Config channel: cfg_valid_i with cfg_ready_o (always high), cfg_index_i selects
// the distance (0) or angle (1) threshold; other indexes are dropped.
// One shared CORDIC stage runs 16 iterations for the heading (vectoring) and 16
// for the reference sin/cos (rotation); one shared 33x33 multiplier then forms
// the four rotation products and the three squares of the distance test.
// Steps: vectoring, heading finish, rotation, multiplies, scaling, squares, final;
// the first item after reset goes from heading finish straight to the final step.
// The input stalls for the whole item; no new item is taken until it is output.
// A stalled result holds the block in its last step; the next item waits.
// Reset clears the reference, restores default thresholds and empties the output.
module odometry_motion_gate_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] odom_x_i,
  input  logic signed [31:0] odom_y_i,
  input  logic signed [15:0] quat_z_i,
  input  logic signed [15:0] quat_w_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               moved_o,
  output logic signed [31:0] delta_forward_o,
  output logic signed [31:0] delta_lateral_o,
  output logic signed [15:0] delta_angle_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [23:0]        cfg_data_i
);
  import omg_pkg::*;

  state_e state_q, state_d;
  logic [STEP_W-1:0] step_q;
  logic [2:0]        k_q;

  logic [23:0] dist_thr_q;
  logic [14:0] angle_thr_q;

  logic signed [31:0] x_q, y_q, ref_x_q, ref_y_q;
  logic signed [15:0] h_q, ref_angle_q;
  logic               ref_valid_q, zero_q, first_q, neg_q, far_q, sq_gt_q;

  logic signed [XY_W-1:0] cx_q, cy_q;
  logic signed [Z_W-1:0]  cz_q;
  logic signed [OP_W-1:0] dx_q, dy_q, c_q, s_q;
  logic signed [PR_W-1:0] prod_q, acc_f_q, acc_l_q, sq_q;
  logic signed [FL_W-1:0] f_q, l_q;

  logic signed [XY_W-1:0] xs, ys, nx, ny;
  logic signed [Z_W-1:0]  nz, at;
  logic                   dpos, last_step;
  logic signed [OP_W-1:0] ma, mb;
  logic                   accept, out_free;

  logic signed [Z_W-1:0]  hr_t;
  logic signed [16:0]     hr;
  logic signed [17:0]     h2;
  logic signed [15:0]     h_w;
  logic signed [XY_W-1:0] zz, ww;
  logic signed [Z_W-1:0]  za;
  logic signed [16:0]     dd;
  logic signed [15:0]     da;
  logic [15:0]            da_abs;
  logic signed [FL_W-1:0] thr_e;
  logic                   moved_now;

  assign accept    = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_o || !out_stall_i;
  assign last_step = (step_q == STEP_W'(CORDIC_STEPS - 1));
  assign cfg_ready_o = 1'b1;

  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_VEC;
      ST_VEC:  if (last_step) state_d = ST_HFIN;
      ST_HFIN: state_d = ref_valid_q ? ST_ROT : ST_FIN;
      ST_ROT:  if (last_step) state_d = ST_MUL;
      ST_MUL:  if (k_q == 3'd4) state_d = ST_FL;
      ST_FL:   state_d = ST_SQ;
      ST_SQ:   if (k_q == 3'd3) state_d = ST_FIN;
      ST_FIN:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // shared CORDIC stage
  always_comb begin
    xs   = cx_q >>> step_q;
    ys   = cy_q >>> step_q;
    at   = atan_q24(step_q);
    dpos = (state_q == ST_VEC) ? cy_q[XY_W-1] : !cz_q[Z_W-1];
    nx   = dpos ? cx_q - ys : cx_q + ys;
    ny   = dpos ? cy_q + xs : cy_q - xs;
    nz   = dpos ? cz_q - at : cz_q + at;
  end

  // shared multiplier operands
  always_comb begin
    ma = dx_q;
    mb = c_q;
    if (state_q == ST_MUL) begin
      unique case (k_q)
        3'd0:    begin ma = dx_q; mb = c_q; end
        3'd1:    begin ma = dy_q; mb = s_q; end
        3'd2:    begin ma = dy_q; mb = c_q; end
        default: begin ma = dx_q; mb = s_q; end
      endcase
    end else begin
      unique case (k_q)
        3'd0:    begin ma = f_q[OP_W-1:0]; mb = f_q[OP_W-1:0]; end
        3'd1:    begin ma = l_q[OP_W-1:0]; mb = l_q[OP_W-1:0]; end
        default: begin
          ma = $signed({9'd0, dist_thr_q});
          mb = $signed({9'd0, dist_thr_q});
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      k_q         <= '0;
      dist_thr_q  <= DIST_THR_RST;
      angle_thr_q <= ANGLE_THR_RST;
      ref_valid_q <= 1'b0;
      ref_x_q     <= '0;
      ref_y_q     <= '0;
      ref_angle_q <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == REG_DIST) dist_thr_q <= cfg_data_i;
        else if (cfg_index_i == REG_ANGLE) angle_thr_q <= cfg_data_i[14:0];
      end
      if (state_q == ST_FIN && out_free) begin
        out_valid_o <= 1'b1;
        if (first_q || moved_now) begin
          ref_x_q     <= x_q;
          ref_y_q     <= y_q;
          ref_angle_q <= h_q;
          ref_valid_q <= 1'b1;
        end
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
      if (state_q == ST_VEC || state_q == ST_ROT) begin
        step_q <= last_step ? '0 : step_q + 1'b1;
      end
      if (state_q == ST_MUL) k_q <= (k_q == 3'd4) ? '0 : k_q + 1'b1;
      else if (state_q == ST_SQ) k_q <= (k_q == 3'd3) ? '0 : k_q + 1'b1;
    end
  end

  // datapath
  always_comb begin
    zz   = XY_W'(quat_z_i);
    ww   = XY_W'(quat_w_i);
    hr_t = cz_q + Z_W'(1024);
    hr   = hr_t[Z_W-1:11];
    h2   = {hr, 1'b0};
    if (h2 > 18'(PI_Q13)) h_w = 16'(h2 - TWO_PI_Q13);
    else if (h2 <= -18'(PI_Q13)) h_w = 16'(h2 + TWO_PI_Q13);
    else h_w = h2[15:0];
    za = $signed({ref_angle_q[15], ref_angle_q, 11'd0});
    dd = 17'(h_q) - 17'(ref_angle_q);
    if (dd > PI_Q13) da = 16'(dd - 17'(TWO_PI_Q13));
    else if (dd <= -PI_Q13) da = 16'(dd + 17'(TWO_PI_Q13));
    else da = dd[15:0];
    da_abs    = da[15] ? 16'(-da) : da;
    thr_e     = $signed({14'd0, dist_thr_q});
    moved_now = !first_q && (far_q || sq_gt_q || (da_abs > {1'b0, angle_thr_q}));
  end

  always_ff @(posedge clk_i) begin
    prod_q <= ma * mb;
    unique case (state_q)
      ST_IDLE: if (accept) begin
        x_q     <= odom_x_i;
        y_q     <= odom_y_i;
        first_q <= !ref_valid_q;
        zero_q  <= (quat_z_i == '0) && (quat_w_i == '0);
        if (!quat_w_i[15]) begin
          cx_q <= ww <<< 14; cy_q <= zz <<< 14; cz_q <= '0;
        end else if (!quat_z_i[15]) begin
          cx_q <= zz <<< 14; cy_q <= (-ww) <<< 14; cz_q <= HALF_PI_Q24;
        end else begin
          cx_q <= (-zz) <<< 14; cy_q <= ww <<< 14; cz_q <= -HALF_PI_Q24;
        end
      end
      ST_VEC, ST_ROT: begin
        cx_q <= nx; cy_q <= ny; cz_q <= nz;
        if (state_q == ST_ROT && last_step) begin
          c_q <= OP_W'(neg_q ? -nx : nx);
          s_q <= OP_W'(neg_q ? -ny : ny);
        end
      end
      ST_HFIN: begin
        h_q  <= zero_q ? '0 : h_w;
        dx_q <= OP_W'(x_q) - OP_W'(ref_x_q);
        dy_q <= OP_W'(y_q) - OP_W'(ref_y_q);
        cx_q <= GAIN_Q28;
        cy_q <= '0;
        if (za > HALF_PI_Q24) begin
          cz_q <= za - PI_Q24; neg_q <= 1'b1;
        end else if (za < -HALF_PI_Q24) begin
          cz_q <= za + PI_Q24; neg_q <= 1'b1;
        end else begin
          cz_q <= za; neg_q <= 1'b0;
        end
      end
      ST_MUL: begin
        unique case (k_q)
          3'd1:    acc_f_q <= prod_q;
          3'd2:    acc_f_q <= acc_f_q + prod_q;
          3'd3:    acc_l_q <= prod_q;
          3'd4:    acc_l_q <= acc_l_q - prod_q;
          default: ;
        endcase
      end
      ST_FL: begin
        f_q <= FL_W'((acc_f_q + PR_W'(64'sd134217728)) >>> 28);
        l_q <= FL_W'((acc_l_q + PR_W'(64'sd134217728)) >>> 28);
      end
      ST_SQ: begin
        unique case (k_q)
          3'd0: far_q <= (f_q > thr_e) || (-f_q > thr_e) ||
                         (l_q > thr_e) || (-l_q > thr_e);
          3'd1: sq_q  <= prod_q;
          3'd2: sq_q  <= sq_q + prod_q;
          default: sq_gt_q <= sq_q > prod_q;
        endcase
      end
      ST_FIN: if (out_free) begin
        moved_o <= moved_now;
        if (first_q) begin
          delta_forward_o <= '0;
          delta_lateral_o <= '0;
          delta_angle_o   <= '0;
        end else begin
          delta_forward_o <= (f_q > FL_W'(32'sh7fffffff)) ? 32'sh7fffffff :
                             (f_q < -FL_W'(33'sh80000000)) ? 32'sh80000000 : f_q[31:0];
          delta_lateral_o <= (l_q > FL_W'(32'sh7fffffff)) ? 32'sh7fffffff :
                             (l_q < -FL_W'(33'sh80000000)) ? 32'sh80000000 : l_q[31:0];
          delta_angle_o   <= da;
        end
      end
      default: ;
    endcase
  end

endmodule
